@@ hw/rtl/dgn_pkg.sv @@
// ----------------------------------------------------------------------------
// dgn_pkg
// Shared types, codes and helpers of the depth-to-grayscale normalizer.
// ----------------------------------------------------------------------------
package dgn_pkg;

   localparam int DEPTH_W = 32;
   localparam int COLOR_W = 16;
   localparam int MODE_W  = 2;
   localparam int GRAY_W  = 8;
   localparam int CSR_IDX_W = 1;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCAN    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR        = 1'd1;

   localparam logic signed [DEPTH_W-1:0] DEPTH_MOST_POS = 32'sh7FFF_FFFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MOST_NEG = 32'sh8000_0000;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 16'h6330;
   localparam logic [DEPTH_W-1:0] Q16_ONE = 32'd65536;
   localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;
   localparam int DIV_STEPS = GRAY_W;

   typedef struct packed {
      logic load;      // capture accepted transaction
      logic exec;      // update statistics or form diff and range
      logic prep;      // scale numerator, classify saturation
      logic div_step;  // one restoring divider step
      logic emit;      // write result register
   } cmd_type;

   typedef struct packed {
      logic is_convert;
      logic use_div;
   } sts_type;

   function automatic logic [COLOR_W-1:0] pack_gray(input logic [GRAY_W-1:0] g);
      return {g[7:3], g[7:2], g[7:3]};
   endfunction

endpackage

@@ hw/rtl/dgn_req_if.sv @@
// ----------------------------------------------------------------------------
// dgn_req_if
// Request channel: mode and depth sample with valid/ready.
// ----------------------------------------------------------------------------
interface dgn_req_if;
   logic                                valid;
   logic                                ready;
   logic [dgn_pkg::MODE_W-1:0]          mode;
   logic signed [dgn_pkg::DEPTH_W-1:0]  depth;

   modport source (output valid, output mode, output depth, input ready);
   modport sink   (input valid, input mode, input depth, output ready);
endinterface

@@ hw/rtl/dgn_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dgn_rsp_if
// Response channel: RGB565 pixel and background flag with valid/ready.
// ----------------------------------------------------------------------------
interface dgn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dgn_pkg::COLOR_W-1:0]   color;
   logic                          is_background;

   modport source (output valid, output color, output is_background, input ready);
   modport sink   (input valid, input color, input is_background, output ready);
endinterface

@@ hw/rtl/dgn_ctrl.sv @@
// ----------------------------------------------------------------------------
// dgn_ctrl
// Sequencer: accepts a transaction, walks it through the datapath steps and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module dgn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dgn_pkg::sts_type  sts,
   output dgn_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   localparam int CNT_W = $clog2(dgn_pkg::DIV_STEPS);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_convert ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // skip the divider for background and saturated pixels
            if (!sts.use_div) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(dgn_pkg::DIV_STEPS - 1)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // hold until the result register can take the pixel
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/dgn_datapath.sv @@
// ----------------------------------------------------------------------------
// dgn_datapath
// Registers, min/max statistics, range/diff arithmetic, 8-step restoring
// divider and RGB565 packing.
// ----------------------------------------------------------------------------
module dgn_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dgn_pkg::cmd_type                     cmd,
   output dgn_pkg::sts_type                     sts,
   input  logic [dgn_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [dgn_pkg::DEPTH_W-1:0]   req_depth,
   input  logic                                 csr_we,
   input  logic [dgn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dgn_pkg::DEPTH_W-1:0]          csr_wdata,
   output logic [dgn_pkg::COLOR_W-1:0]          rsp_color,
   output logic                                 rsp_is_background
);

   localparam int DW = dgn_pkg::DEPTH_W;
   localparam int GW = dgn_pkg::GRAY_W;

   // control-state registers
   logic signed [DW-1:0]          thr_ff, thr_in;
   logic [dgn_pkg::COLOR_W-1:0]   bg_ff, bg_in;
   logic signed [DW-1:0]          min_ff, min_in;
   logic signed [DW-1:0]          max_ff, max_in;
   logic                          found_ff, found_in;

   // payload registers
   logic [dgn_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic signed [DW-1:0]          z_ff, z_in;
   logic signed [DW:0]            diff_ff, diff_in;
   logic [DW-1:0]                 range_ff, range_in;
   logic                          bg_sel_ff, bg_sel_in;
   logic                          use_div_ff, use_div_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   logic [GW-1:0]                 numlo_ff, numlo_in;
   logic [GW-1:0]                 gray_ff, gray_in;
   logic [dgn_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic                          isbg_ff, isbg_in;

   logic signed [DW:0]            diff_calc, range_calc;
   logic                          z_nonempty;
   logic                          diff_le0, diff_ge;
   logic [DW+GW-1:0]              num;
   logic [DW:0]                   r2, r2_sub;
   logic                          r2_ge;

   assign sts.is_convert = (mode_ff == dgn_pkg::MODE_CONVERT);
   assign sts.use_div    = use_div_ff;

   assign rsp_color         = color_ff;
   assign rsp_is_background = isbg_ff;

   assign z_nonempty = (z_ff > thr_ff);
   assign diff_calc  = {z_ff[DW-1], z_ff} - {min_ff[DW-1], min_ff};
   assign range_calc = {max_ff[DW-1], max_ff} - {min_ff[DW-1], min_ff};

   assign diff_le0 = diff_ff[DW] || (diff_ff == '0);
   assign diff_ge  = !diff_ff[DW] && (diff_ff[DW-1:0] >= range_ff);
   // diff * 255 as (diff << 8) - diff
   assign num = {diff_ff[DW-1:0], {GW{1'b0}}} - {{GW{1'b0}}, diff_ff[DW-1:0]};

   assign r2     = {rem_ff, numlo_ff[GW-1]};
   assign r2_sub = r2 - {1'b0, range_ff};
   assign r2_ge  = (r2 >= {1'b0, range_ff});

   always_comb begin
      thr_in     = thr_ff;
      bg_in      = bg_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      found_in   = found_ff;
      mode_in    = mode_ff;
      z_in       = z_ff;
      diff_in    = diff_ff;
      range_in   = range_ff;
      bg_sel_in  = bg_sel_ff;
      use_div_in = use_div_ff;
      rem_in     = rem_ff;
      numlo_in   = numlo_ff;
      gray_in    = gray_ff;
      color_in   = color_ff;
      isbg_in    = isbg_ff;

      if (csr_we) begin
         case (csr_index)
            dgn_pkg::CSR_EMPTY_THRESHOLD: thr_in = csr_wdata;
            dgn_pkg::CSR_BG_COLOR:        bg_in  = csr_wdata[dgn_pkg::COLOR_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         mode_in = req_mode;
         z_in    = req_depth;
      end

      if (cmd.exec) begin
         case (mode_ff)
            dgn_pkg::MODE_CLEAR: begin
               min_in   = dgn_pkg::DEPTH_MOST_POS;
               max_in   = dgn_pkg::DEPTH_MOST_NEG;
               found_in = 1'b0;
            end
            dgn_pkg::MODE_SCAN: begin
               // drop empty samples
               if (z_nonempty) begin
                  if (z_ff < min_ff) min_in = z_ff;
                  if (z_ff > max_ff) max_in = z_ff;
                  found_in = 1'b1;
               end
            end
            dgn_pkg::MODE_CONVERT: begin
               diff_in   = diff_calc;
               range_in  = (range_calc == '0) ? dgn_pkg::Q16_ONE : range_calc[DW-1:0];
               bg_sel_in = !found_ff || !z_nonempty;
            end
            default: begin
            end
         endcase
      end

      if (cmd.prep) begin
         rem_in     = num[DW+GW-1:GW];
         numlo_in   = num[GW-1:0];
         use_div_in = !bg_sel_ff && !diff_le0 && !diff_ge;
         gray_in    = (diff_ge && !diff_le0) ? dgn_pkg::GRAY_MAX : '0;
      end

      if (cmd.div_step) begin
         rem_in   = r2_ge ? r2_sub[DW-1:0] : r2[DW-1:0];
         numlo_in = {numlo_ff[GW-2:0], 1'b0};
         gray_in  = {gray_ff[GW-2:0], r2_ge};
      end

      if (cmd.emit) begin
         color_in = bg_sel_ff ? bg_ff : dgn_pkg::pack_gray(gray_ff);
         isbg_in  = bg_sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= dgn_pkg::DEPTH_MOST_NEG;
         bg_ff      <= dgn_pkg::BG_COLOR_RESET;
         min_ff     <= dgn_pkg::DEPTH_MOST_POS;
         max_ff     <= dgn_pkg::DEPTH_MOST_NEG;
         found_ff   <= 1'b0;
         mode_ff    <= dgn_pkg::MODE_CLEAR;
         use_div_ff <= 1'b0;
      end else begin
         thr_ff     <= thr_in;
         bg_ff      <= bg_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         found_ff   <= found_in;
         mode_ff    <= mode_in;
         use_div_ff <= use_div_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff      <= z_in;
      diff_ff   <= diff_in;
      range_ff  <= range_in;
      bg_sel_ff <= bg_sel_in;
      rem_ff    <= rem_in;
      numlo_ff  <= numlo_in;
      gray_ff   <= gray_in;
      color_ff  <= color_in;
      isbg_ff   <= isbg_in;
   end

endmodule

@@ hw/rtl/depth_to_grayscale_normalizer.sv @@
// A convert transaction goes through CALC, PREP, DIV and EMIT after acceptance
// (background or saturated pixels skip the divider steps in DIV).
// A new request is accepted only in IDLE, after the previous one has left EMIT;
// clear and scan transactions produce no response.
// The response register lets the next request enter while a pixel waits.
// Reset (synchronous): statistics cleared, threshold most negative, bg 0x6330.
// ----------------------------------------------------------------------------
// depth_to_grayscale_normalizer
// Min/max depth normalization of Q15.16 depth samples to RGB565 gray pixels.
// ----------------------------------------------------------------------------
module depth_to_grayscale_normalizer (
   input  logic                                  clock,
   input  logic                                  reset,
   dgn_req_if.sink                               req,
   dgn_rsp_if.source                             rsp,
   input  logic                                  csr_we,
   input  logic [dgn_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dgn_pkg::DEPTH_W-1:0]           csr_wdata
);

   dgn_pkg::cmd_type  cmd;
   dgn_pkg::sts_type  sts;

   dgn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dgn_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req.mode),
      .req_depth         (req.depth),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_color         (rsp.color),
      .rsp_is_background (rsp.is_background)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives mode/depth transactions into depth_to_grayscale_normalizer through
// its request channel and checks every RGB565 pixel against an in-bench model
// or a table. The directed rows cover empty frames, empty samples, zero range,
// saturation and the extremes of the depth field. After them, random phases
// under several threshold and background settings run clear/scan/convert
// frames with stray transactions mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DW  = dgn_pkg::DEPTH_W;
   localparam int CW  = dgn_pkg::COLOR_W;
   localparam int MW  = dgn_pkg::MODE_W;
   localparam int GW  = dgn_pkg::GRAY_W;
   localparam int IW  = dgn_pkg::CSR_IDX_W;

   localparam logic [MW-1:0] MODE_IGNORED = 2'd3;
   localparam logic BY_TABLE     = 1'b1;
   localparam logic BY_PREDICTOR = 1'b0;
   localparam longint DEPTH_LO = dgn_pkg::DEPTH_MOST_NEG;
   localparam longint DEPTH_HI = dgn_pkg::DEPTH_MOST_POS;

   localparam int N_PHASES       = 8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [CW-1:0] color;
      logic          is_bg;
   } pixel_type;

   typedef struct packed {
      logic [MW-1:0] mode;
      logic [DW-1:0] depth;
      logic          check;
      logic [CW-1:0] color;
      logic          is_bg;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          csr_we;
   logic [IW-1:0] csr_index;
   logic [DW-1:0] csr_wdata;

   dgn_req_if req ();
   dgn_rsp_if rsp ();

   depth_to_grayscale_normalizer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and frame statistics
   logic signed [DW-1:0] cfg_threshold;
   logic [CW-1:0]        cfg_bg;
   logic signed [DW-1:0] stat_min;
   logic signed [DW-1:0] stat_max;
   logic                 stat_found;

   pixel_type expected_pixels [$];

   int items_sent;
   int pixels_predicted;
   int bg_predicted;
   int pixels_seen;
   int mismatches;
   int idle_cycles;
   int burst_left;

   localparam int PHASE_ITEMS [N_PHASES] = '{250, 60, 240, 240, 240, 240, 240, 240};

   localparam logic [MW-1:0] M_CLR = dgn_pkg::MODE_CLEAR;
   localparam logic [MW-1:0] M_SCN = dgn_pkg::MODE_SCAN;
   localparam logic [MW-1:0] M_CNV = dgn_pkg::MODE_CONVERT;
   localparam logic [CW-1:0] BG_RST = dgn_pkg::BG_COLOR_RESET;

   localparam int N_DIRECTED = 25;
   stim_row_type directed_rows [N_DIRECTED] = '{
      // nothing found yet: background at reset color
      '{M_CNV,        32'h0000_0000, BY_TABLE, BG_RST, 1'b1},
      '{MODE_IGNORED, 32'h7FFF_FFFF, BY_PREDICTOR, 16'h0000, 1'b0},
      // most negative depth sits at the reset threshold: empty, skipped
      '{M_SCN,        32'h8000_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CNV,        32'h8000_0000, BY_TABLE, BG_RST, 1'b1},
      '{M_SCN,        32'h7FFF_FFFF, BY_PREDICTOR, 16'h0000, 1'b0},
      // zero range: replaced by one unit, depth at min gives black
      '{M_CNV,        32'h7FFF_FFFF, BY_TABLE, 16'h0000, 1'b0},
      '{M_CNV,        32'h8000_0001, BY_TABLE, 16'h0000, 1'b0},
      '{M_SCN,        32'h8000_0001, BY_PREDICTOR, 16'h0000, 1'b0},
      // full 32-bit range
      '{M_CNV,        32'h7FFF_FFFF, BY_TABLE, 16'hFFFF, 1'b0},
      '{M_CNV,        32'h8000_0001, BY_TABLE, 16'h0000, 1'b0},
      '{M_CNV,        32'h0000_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CNV,        32'h8000_0000, BY_TABLE, BG_RST, 1'b1},
      '{M_CLR,        32'hFFFF_FFFF, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CNV,        32'h1234_5678, BY_TABLE, BG_RST, 1'b1},
      '{M_SCN,        32'h0001_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_SCN,        32'h0003_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CNV,        32'h0002_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CNV,        32'h0003_0000, BY_TABLE, 16'hFFFF, 1'b0},
      '{M_CNV,        32'h0001_0000, BY_TABLE, 16'h0000, 1'b0},
      // above max and below min saturate
      '{M_CNV,        32'h0004_0000, BY_TABLE, 16'hFFFF, 1'b0},
      '{M_CNV,        32'h0000_0000, BY_TABLE, 16'h0000, 1'b0},
      '{M_CNV,        32'h0001_FFFF, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_CLR,        32'h0000_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      '{M_SCN,        32'h0005_0000, BY_PREDICTOR, 16'h0000, 1'b0},
      // single sample: half a unit above it lands mid-scale
      '{M_CNV,        32'h0005_8000, BY_PREDICTOR, 16'h0000, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one transaction to the shadow state; returns 1 when a pixel is due.
   function automatic bit normalize_item(input logic [MW-1:0] mode,
                                         input logic signed [DW-1:0] z,
                                         output pixel_type px);
      longint span;
      longint diff;
      logic [GW-1:0] g;
      bit made;
      made = 1'b0;
      px = '{color: '0, is_bg: 1'b0};
      case (mode)
         dgn_pkg::MODE_CLEAR: begin
            stat_min = dgn_pkg::DEPTH_MOST_POS;
            stat_max = dgn_pkg::DEPTH_MOST_NEG;
            stat_found = 1'b0;
         end
         dgn_pkg::MODE_SCAN: begin
            if (z > cfg_threshold) begin
               if (z < stat_min) stat_min = z;
               if (z > stat_max) stat_max = z;
               stat_found = 1'b1;
            end
         end
         dgn_pkg::MODE_CONVERT: begin
            made = 1'b1;
            if (!stat_found || z <= cfg_threshold) begin
               px = '{color: cfg_bg, is_bg: 1'b1};
            end else begin
               span = longint'(stat_max) - longint'(stat_min);
               diff = longint'(z) - longint'(stat_min);
               if (span <= 0) span = longint'(dgn_pkg::Q16_ONE);
               if (diff <= 0) g = '0;
               else if (diff >= span) g = dgn_pkg::GRAY_MAX;
               else g = GW'((diff * longint'(dgn_pkg::GRAY_MAX)) / span);
               px.color = (CW'(g >> 3) << 11) | (CW'(g >> 2) << 5)
                        | CW'(g >> 3);
            end
         end
         default: ;
      endcase
      return made;
   endfunction

   // Uniform depth in [lo, hi], both clipped to the Q15.16 range.
   function automatic logic signed [DW-1:0] depth_between(input longint lo,
                                                          input longint hi);
      longint unsigned span;
      longint unsigned r;
      if (lo < DEPTH_LO) lo = DEPTH_LO;
      if (hi > DEPTH_HI) hi = DEPTH_HI;
      if (hi < lo) hi = lo;
      span = longint'(hi - lo + 1);
      r = {$urandom, $urandom};
      return DW'(lo + longint'(r % span));
   endfunction

   function automatic logic signed [DW-1:0] convert_depth(input longint lo,
                                                          input longint hi);
      longint margin;
      int unsigned sel;
      margin = (hi - lo) / 4 + 1;
      sel = $urandom_range(0, 19);
      if (sel < 11) return depth_between(lo, hi);
      else if (sel < 14) return depth_between(lo - margin, lo);
      else if (sel < 16) return depth_between(hi, hi + margin);
      else if (sel == 16) return ($urandom_range(0, 1) != 0) ? stat_min : stat_max;
      else if (sel == 17) return depth_between(cfg_threshold, longint'(cfg_threshold) + 1);
      else if (sel == 18) return DW'($urandom);
      else return ($urandom_range(0, 1) != 0) ? dgn_pkg::DEPTH_MOST_NEG
                                              : dgn_pkg::DEPTH_MOST_POS;
   endfunction

   function automatic stim_row_type as_item(input logic [MW-1:0] mode,
                                            input logic [DW-1:0] depth);
      return '{mode: mode, depth: depth, check: BY_PREDICTOR, color: '0, is_bg: 1'b0};
   endfunction

   // Starts and ends at a falling edge; the sender idles between bursts.
   task automatic send_item(input stim_row_type row);
      pixel_type px;
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.mode  <= row.mode;
      req.depth <= row.depth;
      do @(posedge clock); while (!req.ready);
      if (normalize_item(row.mode, row.depth, px)) begin
         if (row.check == BY_TABLE) px = '{color: row.color, is_bg: row.is_bg};
         expected_pixels.push_back(px);
         pixels_predicted++;
         if (px.is_bg) bg_predicted++;
      end
      if (row.mode != MODE_IGNORED) items_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending pixel, then let the pipeline settle.
   task automatic wait_idle();
      req.valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         dgn_pkg::CSR_EMPTY_THRESHOLD: cfg_threshold = value;
         dgn_pkg::CSR_BG_COLOR:        cfg_bg = value[CW-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Mostly clear / scan / convert frames with random content, plus strays.
   task automatic run_phase(input int target);
      int first;
      longint win_lo;
      longint win_hi;
      first = items_sent;
      while (items_sent - first < target) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3))
               send_item(as_item(MW'($urandom_range(0, 3)), $urandom));
         end else begin
            if ($urandom_range(0, 2) == 0) win_lo = longint'(int'($urandom));
            else win_lo = depth_between(-(longint'(100) <<< 16), longint'(100) <<< 16);
            win_hi = win_lo + (longint'(1) << $urandom_range(0, 32)) - 1;
            if ($urandom_range(0, 7) != 0) send_item(as_item(M_CLR, $urandom));
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 7) == 0)
                  send_item(as_item(M_SCN, depth_between(DEPTH_LO, cfg_threshold)));
               else
                  send_item(as_item(M_SCN, depth_between(win_lo, win_hi)));
            end
            repeat ($urandom_range(1, 12))
               send_item(as_item(M_CNV, convert_depth(win_lo, win_hi)));
         end
      end
   endtask

   // Receiver: ready follows a changing pattern, with one long hold-off.
   initial begin
      int style;
      int style_left;
      bit held_off;
      style = 0;
      style_left = 0;
      held_off = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && pixels_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(32, 256);
         end
         style_left--;
         case (style)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= style_left[2];
         endcase
      end
   end

   // Pixel checker and watchdog.
   always @(posedge clock) begin
      pixel_type want;
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) idle_cycles = 0;
      else idle_cycles++;
      if (!reset && rsp.valid && rsp.ready) begin
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("pixel %0d: no convert pending, got color %h bg %0d",
                        pixels_seen, rsp.color, rsp.is_background);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp.color !== want.color || rsp.is_background !== want.is_bg) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("pixel %0d: expected color %h bg %0d, got color %h bg %0d",
                           pixels_seen, want.color, want.is_bg, rsp.color, rsp.is_background);
            end
         end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d pixels pending",
                  idle_cycles, expected_pixels.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      logic signed [DW-1:0] thr;
      logic [CW-1:0] bg;
      reset = 1'b1;
      req.valid = 1'b0;
      req.mode = dgn_pkg::MODE_CLEAR;
      req.depth = '0;
      csr_we = 1'b0;
      csr_index = dgn_pkg::CSR_EMPTY_THRESHOLD;
      csr_wdata = '0;
      cfg_threshold = dgn_pkg::DEPTH_MOST_NEG;
      cfg_bg = dgn_pkg::BG_COLOR_RESET;
      stat_min = dgn_pkg::DEPTH_MOST_POS;
      stat_max = dgn_pkg::DEPTH_MOST_NEG;
      stat_found = 1'b0;
      items_sent = 0;
      pixels_predicted = 0;
      bg_predicted = 0;
      pixels_seen = 0;
      mismatches = 0;
      idle_cycles = 0;
      burst_left = 0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_idle();

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin thr = dgn_pkg::DEPTH_MOST_NEG; bg = 16'h0000; end
            1: begin thr = dgn_pkg::DEPTH_MOST_POS; bg = 16'hFFFF; end
            2: begin thr = '0; bg = CW'($urandom); end
            default: begin
               if ($urandom_range(0, 1) != 0) thr = DW'($urandom);
               else thr = depth_between(-(longint'(100) <<< 16), longint'(100) <<< 16);
               bg = CW'($urandom);
            end
         endcase
         write_reg(dgn_pkg::CSR_EMPTY_THRESHOLD, thr);
         // upper data bits are don't-care for the color register
         write_reg(dgn_pkg::CSR_BG_COLOR, {16'($urandom), bg});
         run_phase(PHASE_ITEMS[p]);
         wait_idle();
      end

      $display("%0d transactions over %0d register settings plus reset defaults",
               items_sent, N_PHASES);
      $display("%0d pixels checked (%0d background), %0d mismatches",
               pixels_seen, bg_predicted, mismatches);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/dgn_pkg.sv
hw/rtl/dgn_req_if.sv
hw/rtl/dgn_rsp_if.sv
hw/rtl/dgn_ctrl.sv
hw/rtl/dgn_datapath.sv
hw/rtl/depth_to_grayscale_normalizer.sv
tb/testbench.sv
